// File: hw/rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, operation codes, recency-table commands and shared types.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int OCC_W   = 5;
    localparam int KIND_W  = 2;
    localparam int CAP_RESET = 16;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    // Recency table commands.
    localparam int RK_OP_W = 3;
    localparam logic [RK_OP_W-1:0] RK_NONE      = 3'd0;
    localparam logic [RK_OP_W-1:0] RK_TOUCH     = 3'd1;
    localparam logic [RK_OP_W-1:0] RK_REMOVE    = 3'd2;
    localparam logic [RK_OP_W-1:0] RK_ADD       = 3'd3;
    localparam logic [RK_OP_W-1:0] RK_EVICT_ADD = 3'd4;

    typedef struct packed {
        logic [RK_OP_W-1:0] op;
        logic [IDX_W-1:0]   slot;    // slot touched, removed or filled
        logic [IDX_W-1:0]   victim;  // slot evicted, for RK_EVICT_ADD only
    } t_rank_cmd;

    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
    } t_slot_info;

endpackage

// File: hw/rtl/lkv_req_if.sv
// ----------------------------------------------------------------------------
// LRU key-value cache request channel
// Valid/ready channel carrying one operation request.
// ----------------------------------------------------------------------------
interface lkv_req_if;
    logic                        valid;
    logic                        ready;
    logic [lkv_pkg::KIND_W-1:0]  kind;
    logic [lkv_pkg::KEY_W-1:0]   key;
    logic [lkv_pkg::DATA_W-1:0]  value;

    modport source (output valid, kind, key, value, input ready);
    modport sink   (input valid, kind, key, value, output ready);
endinterface

// File: hw/rtl/lkv_rsp_if.sv
// ----------------------------------------------------------------------------
// LRU key-value cache response channel
// Valid/ready channel carrying the result of one request.
// ----------------------------------------------------------------------------
interface lkv_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [lkv_pkg::DATA_W-1:0]  data_out;
    logic                        evicted;
    logic [lkv_pkg::KEY_W-1:0]   evicted_key;
    logic [lkv_pkg::OCC_W-1:0]   occupancy;

    modport source (output valid, found, data_out, evicted, evicted_key, occupancy,
                    input ready);
    modport sink   (input valid, found, data_out, evicted, evicted_key, occupancy,
                    output ready);
endinterface

// File: hw/rtl/lkv_cfg_if.sv
// ----------------------------------------------------------------------------
// LRU key-value cache configuration channel
// Valid/ready write channel for the capacity register.
// ----------------------------------------------------------------------------
interface lkv_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lkv_pkg::CAP_W-1:0]  capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

// File: hw/rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Key-to-data store kept in least-recently-used order, with a settable
// capacity, searched by one shared key comparator under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Carries                                          Accepted when
//  i_req     in    kind, key, value                                 valid && ready
//  o_rsp     out   found, data_out, evicted, evicted_key, occupancy valid && ready
//  i_cfg     in    capacity                                         valid && ready
//
// From acceptance, one comparator walks the key store one entry a cycle
// through its registered read port, and the commit state then commits the
// store and recency updates and registers the response. A new request is
// taken once the previous one has committed, even while its response still
// waits in the output register.
// Reset is synchronous and active low; it empties the store and sets the
// capacity to 16. A stalled response holds the sequencer in its commit cycle.
//
module lru_key_value_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lkv_req_if.sink     i_req,
    lkv_rsp_if.source   o_rsp,
    lkv_cfg_if.sink     i_cfg
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                   r_state;
    logic [lkv_pkg::IDX_W:0]      r_idx;       // next entry to read from the store
    logic                         r_chk;       // read data of r_chk_idx is present
    logic [lkv_pkg::IDX_W-1:0]    r_chk_idx;

    // The request being served.
    logic [lkv_pkg::KIND_W-1:0]   r_kind;
    logic [lkv_pkg::KEY_W-1:0]    r_key;
    logic [lkv_pkg::DATA_W-1:0]   r_value;

    // What the scan has found so far.
    logic                         r_hit;
    logic [lkv_pkg::IDX_W-1:0]    r_hit_slot;
    logic [lkv_pkg::DATA_W-1:0]   r_hit_data;
    logic                         r_lru;
    logic [lkv_pkg::IDX_W-1:0]    r_lru_slot;
    logic [lkv_pkg::KEY_W-1:0]    r_lru_key;
    logic                         r_free;
    logic [lkv_pkg::IDX_W-1:0]    r_free_slot;

    logic [lkv_pkg::CAP_W-1:0]    r_cap;

    // Output register.
    logic                         r_out_valid;
    logic                         r_found;
    logic [lkv_pkg::DATA_W-1:0]   r_dout;
    logic                         r_ev;
    logic [lkv_pkg::KEY_W-1:0]    r_evkey;
    logic [lkv_pkg::OCC_W-1:0]    r_occ;

    logic                         req_acc;
    logic                         out_free;
    logic                         commit;

    logic [lkv_pkg::KEY_W-1:0]    rd_key;
    logic [lkv_pkg::DATA_W-1:0]   rd_data;
    lkv_pkg::t_slot_info          info;
    logic [lkv_pkg::CNT_W-1:0]    count;

    logic                         key_eq;
    logic [lkv_pkg::CNT_W-1:0]    eff_cap;
    logic [lkv_pkg::IDX_W-1:0]    ins_slot;

    lkv_pkg::t_rank_cmd           cmd;
    logic                         we;
    logic [lkv_pkg::IDX_W-1:0]    wr_addr;
    logic                         n_found;
    logic [lkv_pkg::DATA_W-1:0]   n_dout;
    logic                         n_ev;
    logic [lkv_pkg::KEY_W-1:0]    n_evkey;
    logic [lkv_pkg::CNT_W-1:0]    n_occ;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign commit      = (r_state == S_DONE) && out_free;

    lkv_store u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_key  (r_key),
        .i_wr_data (r_value),
        .i_rd_addr (r_idx[lkv_pkg::IDX_W-1:0]),
        .o_rd_key  (rd_key),
        .o_rd_data (rd_data)
    );

    lkv_rank u_rank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_rd_idx (r_chk_idx),
        .o_info   (info),
        .o_count  (count)
    );

    // The one shared key comparator.
    assign key_eq = (rd_key == r_key);

    // A capacity of zero acts as one, and one above the store size as the size.
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = lkv_pkg::CNT_W'(1);
        end else if (int'(r_cap) > lkv_pkg::ENTRIES) begin
            eff_cap = lkv_pkg::CNT_W'(lkv_pkg::ENTRIES);
        end else begin
            eff_cap = lkv_pkg::CNT_W'(r_cap);
        end
    end

    // After an eviction the victim's slot is free too; the lowest free slot wins.
    assign ins_slot = (r_free && (r_free_slot < r_lru_slot)) ? r_free_slot : r_lru_slot;

    // Decisions of the commit cycle.
    always_comb begin
        cmd.op     = lkv_pkg::RK_NONE;
        cmd.slot   = r_hit_slot;
        cmd.victim = r_lru_slot;
        we         = 1'b0;
        wr_addr    = r_hit_slot;
        n_found    = 1'b0;
        n_dout     = '0;
        n_ev       = 1'b0;
        n_evkey    = '0;
        n_occ      = count;

        case (r_kind)
            lkv_pkg::KIND_INSERT: begin
                if (r_hit) begin
                    // Update in place: new data, entry becomes the most recent.
                    n_found = 1'b1;
                    we      = 1'b1;
                    cmd.op  = lkv_pkg::RK_TOUCH;
                end else if ((count >= eff_cap) && r_lru) begin
                    // Full: the least recent entry makes room for the new key.
                    n_ev     = 1'b1;
                    n_evkey  = r_lru_key;
                    we       = 1'b1;
                    wr_addr  = ins_slot;
                    cmd.op   = lkv_pkg::RK_EVICT_ADD;
                    cmd.slot = ins_slot;
                end else begin
                    we       = 1'b1;
                    wr_addr  = r_free_slot;
                    cmd.op   = lkv_pkg::RK_ADD;
                    cmd.slot = r_free_slot;
                    n_occ    = count + 1'b1;
                end
            end
            lkv_pkg::KIND_SEARCH: begin
                if (r_hit) begin
                    n_found = 1'b1;
                    n_dout  = r_hit_data;
                    cmd.op  = lkv_pkg::RK_TOUCH;
                end
            end
            lkv_pkg::KIND_DELETE: begin
                if (r_hit) begin
                    n_found = 1'b1;
                    n_dout  = r_hit_data;
                    cmd.op  = lkv_pkg::RK_REMOVE;
                    n_occ   = count - 1'b1;
                end
            end
            default: begin
                // Unknown kind: nothing changes, occupancy is reported as is.
            end
        endcase

        if (!commit) begin
            cmd.op = lkv_pkg::RK_NONE;
            we     = 1'b0;
        end
    end

    // Sequencer and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chk   <= 1'b0;
            r_cap   <= lkv_pkg::CAP_W'(lkv_pkg::CAP_RESET);
        end else begin
            if (i_cfg.valid) begin
                r_cap <= i_cfg.capacity;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_state <= S_SCAN;
                        r_chk   <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_chk <= (r_idx < (lkv_pkg::IDX_W + 1)'(lkv_pkg::ENTRIES));
                    if (r_chk && (r_chk_idx == lkv_pkg::IDX_W'(lkv_pkg::ENTRIES - 1))) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Scan datapath: the request, the read pointer and the findings.
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_kind  <= i_req.kind;
            r_key   <= i_req.key;
            r_value <= i_req.value;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_lru   <= 1'b0;
            r_free  <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_idx     <= r_idx + 1'b1;
            r_chk_idx <= r_idx[lkv_pkg::IDX_W-1:0];
            if (r_chk) begin
                if (info.valid && key_eq && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_slot <= r_chk_idx;
                    r_hit_data <= rd_data;
                end
                if (info.valid && (info.rank == '0) && !r_lru) begin
                    r_lru      <= 1'b1;
                    r_lru_slot <= r_chk_idx;
                    r_lru_key  <= rd_key;
                end
                if (!info.valid && !r_free) begin
                    r_free      <= 1'b1;
                    r_free_slot <= r_chk_idx;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_found <= n_found;
            r_dout  <= n_dout;
            r_ev    <= n_ev;
            r_evkey <= n_evkey;
            r_occ   <= lkv_pkg::OCC_W'(n_occ);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_found;
    assign o_rsp.data_out    = r_dout;
    assign o_rsp.evicted     = r_ev;
    assign o_rsp.evicted_key = r_evkey;
    assign o_rsp.occupancy   = r_occ;

endmodule

// File: hw/rtl/lkv_store.sv
// ----------------------------------------------------------------------------
// LRU key-value cache entry store
// Key and data memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lkv_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [lkv_pkg::IDX_W-1:0]   i_wr_addr,
    input  logic [lkv_pkg::KEY_W-1:0]   i_wr_key,
    input  logic [lkv_pkg::DATA_W-1:0]  i_wr_data,
    input  logic [lkv_pkg::IDX_W-1:0]   i_rd_addr,
    output logic [lkv_pkg::KEY_W-1:0]   o_rd_key,
    output logic [lkv_pkg::DATA_W-1:0]  o_rd_data
);

    logic [lkv_pkg::KEY_W-1:0]  r_key_mem  [lkv_pkg::ENTRIES];
    logic [lkv_pkg::DATA_W-1:0] r_data_mem [lkv_pkg::ENTRIES];
    logic [lkv_pkg::KEY_W-1:0]  r_rd_key;
    logic [lkv_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key_mem[i_wr_addr]  <= i_wr_key;
            r_data_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_key  <= r_key_mem[i_rd_addr];
        r_rd_data <= r_data_mem[i_rd_addr];
    end

    assign o_rd_key  = r_rd_key;
    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/lkv_rank.sv
// ----------------------------------------------------------------------------
// LRU key-value cache recency table
// Valid bits, recency ranks and entry count, updated by one command a cycle.
// ----------------------------------------------------------------------------
module lkv_rank (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lkv_pkg::t_rank_cmd          i_cmd,
    input  logic [lkv_pkg::IDX_W-1:0]   i_rd_idx,
    output lkv_pkg::t_slot_info         o_info,
    output logic [lkv_pkg::CNT_W-1:0]   o_count
);

    logic [lkv_pkg::ENTRIES-1:0] r_valid, n_valid;
    logic [lkv_pkg::RANK_W-1:0]  r_rank [lkv_pkg::ENTRIES];
    logic [lkv_pkg::RANK_W-1:0]  n_rank [lkv_pkg::ENTRIES];
    logic [lkv_pkg::CNT_W-1:0]   r_count, n_count;

    logic [lkv_pkg::IDX_W-1:0]   rem_slot;
    logic [lkv_pkg::RANK_W-1:0]  rem_rank;
    logic                        do_unlink;

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_count = r_count;

        // The slot leaving its place in the order: the victim on an eviction.
        rem_slot  = (i_cmd.op == lkv_pkg::RK_EVICT_ADD) ? i_cmd.victim : i_cmd.slot;
        rem_rank  = r_rank[rem_slot];
        do_unlink = (i_cmd.op == lkv_pkg::RK_TOUCH) || (i_cmd.op == lkv_pkg::RK_REMOVE) ||
                    (i_cmd.op == lkv_pkg::RK_EVICT_ADD);

        // Every more recent entry moves down by one rank.
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (do_unlink && r_valid[i] && (lkv_pkg::IDX_W'(i) != rem_slot) &&
                (r_rank[i] > rem_rank)) begin
                n_rank[i] = r_rank[i] - 1'b1;
            end
        end

        case (i_cmd.op)
            lkv_pkg::RK_TOUCH: begin
                n_rank[i_cmd.slot] = lkv_pkg::RANK_W'(r_count - 1'b1);
            end
            lkv_pkg::RK_REMOVE: begin
                n_valid[i_cmd.slot] = 1'b0;
                n_count             = r_count - 1'b1;
            end
            lkv_pkg::RK_ADD: begin
                n_valid[i_cmd.slot] = 1'b1;
                n_rank[i_cmd.slot]  = lkv_pkg::RANK_W'(r_count);
                n_count             = r_count + 1'b1;
            end
            lkv_pkg::RK_EVICT_ADD: begin
                n_valid[i_cmd.victim] = 1'b0;
                n_valid[i_cmd.slot]   = 1'b1;
                n_rank[i_cmd.slot]    = lkv_pkg::RANK_W'(r_count - 1'b1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank <= n_rank;
    end

    assign o_info.valid = r_valid[i_rd_idx];
    assign o_info.rank  = r_rank[i_rd_idx];
    assign o_count      = r_count;

endmodule

// File: dv/lkv_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key-value cache result checker
// Watches the request, response and capacity channels, keeps its own copy of
// the store and its recency order, and compares every response in order.
// ----------------------------------------------------------------------------
module lkv_result_checker
    import lkv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lkv_req_if   req_mon,
    lkv_rsp_if   rsp_mon,
    lkv_cfg_if   cfg_mon,
    output int   o_fail_count,
    output int   o_outstanding
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } t_lkv_req;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] data_out;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
        logic [OCC_W-1:0]  occupancy;
    } t_lkv_result;

    // Shadow store: one line per slot, age 0 is the least recent line.
    logic [ENTRIES-1:0] line_valid;
    logic [KEY_W-1:0]   line_key  [ENTRIES];
    logic [DATA_W-1:0]  line_data [ENTRIES];
    logic [RANK_W-1:0]  line_age  [ENTRIES];
    int                 line_count;
    logic [CAP_W-1:0]   cap_setting;

    t_lkv_result        awaited_results[$];
    int                 fail_total;

    // Close the gap left in the recency order when slot s leaves its place.
    function automatic void close_age_gap(int s);
        for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i] && i != s && line_age[i] > line_age[s]) begin
                line_age[i] = line_age[i] - 1'b1;
            end
        end
    endfunction

    function automatic void make_most_recent(int s);
        close_age_gap(s);
        line_age[s] = RANK_W'(line_count - 1);
    endfunction

    function automatic void drop_line(int s);
        close_age_gap(s);
        line_valid[s] = 1'b0;
        line_count--;
    endfunction

    function automatic t_lkv_result apply_request(t_lkv_req rq);
        t_lkv_result res;
        int          hit;
        int          cap_eff;
        int          slot;
        res = '0;
        hit = -1;
        cap_eff = int'(cap_setting);
        if (cap_eff == 0) begin
            cap_eff = 1;
        end else if (cap_eff > ENTRIES) begin
            cap_eff = ENTRIES;
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (line_valid[i] && line_key[i] == rq.key) begin
                hit = i;
            end
        end
        case (rq.kind)
            KIND_INSERT: begin
                if (hit >= 0) begin
                    res.found = 1'b1;
                    line_data[hit] = rq.value;
                    make_most_recent(hit);
                end else begin
                    if (line_count >= cap_eff) begin
                        slot = -1;
                        for (int i = ENTRIES - 1; i >= 0; i--) begin
                            if (line_valid[i] && line_age[i] == 0) begin
                                slot = i;
                            end
                        end
                        if (slot >= 0) begin
                            res.evicted     = 1'b1;
                            res.evicted_key = line_key[slot];
                            drop_line(slot);
                        end
                    end
                    slot = -1;
                    for (int i = ENTRIES - 1; i >= 0; i--) begin
                        if (!line_valid[i]) begin
                            slot = i;
                        end
                    end
                    if (slot >= 0) begin
                        line_valid[slot] = 1'b1;
                        line_key[slot]   = rq.key;
                        line_data[slot]  = rq.value;
                        line_age[slot]   = RANK_W'(line_count);
                        line_count++;
                    end
                end
            end
            KIND_SEARCH: begin
                if (hit >= 0) begin
                    res.found    = 1'b1;
                    res.data_out = line_data[hit];
                    make_most_recent(hit);
                end
            end
            KIND_DELETE: begin
                if (hit >= 0) begin
                    res.found    = 1'b1;
                    res.data_out = line_data[hit];
                    drop_line(hit);
                end
            end
            default: begin
            end
        endcase
        res.occupancy = OCC_W'(line_count);
        return res;
    endfunction

    function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_lkv_result want;
        t_lkv_req    rq;
        if (!i_rst_n) begin
            line_valid  = '0;
            line_count  = 0;
            cap_setting = CAP_W'(CAP_RESET);
            awaited_results.delete();
            fail_total  = 0;
        end else begin
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected response: expected none, actual %b %h %b %h %0d",
                             $time, rsp_mon.found, rsp_mon.data_out, rsp_mon.evicted,
                             rsp_mon.evicted_key, rsp_mon.occupancy);
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    fail_total += field_mismatch("found", 32'(want.found), 32'(rsp_mon.found));
                    fail_total += field_mismatch("data_out", 32'(want.data_out),
                                                 32'(rsp_mon.data_out));
                    fail_total += field_mismatch("evicted", 32'(want.evicted),
                                                 32'(rsp_mon.evicted));
                    fail_total += field_mismatch("evicted_key", 32'(want.evicted_key),
                                                 32'(rsp_mon.evicted_key));
                    fail_total += field_mismatch("occupancy", 32'(want.occupancy),
                                                 32'(rsp_mon.occupancy));
                end
            end
            if (cfg_mon.valid && cfg_mon.ready) begin
                cap_setting = cfg_mon.capacity;
            end
            if (req_mon.valid && req_mon.ready) begin
                rq.kind  = req_mon.kind;
                rq.key   = req_mon.key;
                rq.value = req_mon.value;
                awaited_results.push_back(apply_request(rq));
            end
        end
        o_outstanding <= awaited_results.size();
        o_fail_count  <= fail_total;
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Directed corner requests, then phases of random requests over small key
// pools at many capacity settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import lkv_pkg::*;

    // The fourth request kind is not decoded by the block: it must be a no-op.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Random requests that do real work before the run winds down.
    localparam int RANDOM_REQUESTS = 1400;

    logic i_clk;
    logic i_rst_n;

    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();
    lkv_cfg_if cfg_ch ();

    int fail_count;
    int outstanding;

    // When set, neither side inserts any idle cycles.
    bit quiet_phase;

    logic [KEY_W-1:0] key_pool[$];

    lru_key_value_cache DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    lkv_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .req_mon       (req_ch),
        .rsp_mon       (rsp_ch),
        .cfg_mon       (cfg_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run: every request waiting out
    // the longest sender gap, the sequencer walk and the longest receiver stall.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Length of one idle stretch: mostly from the shortest range, now and then from the longest.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Response side: ready drops for random stretches so that stalls land on
    // the commit cycle as well as on a response already waiting.
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                    stall_left = idle_cycles();
                end
            end
        end
    end

    // Presents one request and returns at the edge where it is accepted, with
    // valid still high so that a back-to-back request follows without a gap.
    task automatic send_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                logic [DATA_W-1:0] value);
        int gap;
        gap = 0;
        if (!quiet_phase && $urandom_range(0, 9) < 4) begin
            gap = idle_cycles();
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.key   <= key;
        req_ch.value <= value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Holds the request side off until every response has come back.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // The capacity is only changed with the block idle; every request yields a
    // response, so an empty checker queue means the sequencer has finished.
    task automatic set_capacity(logic [CAP_W-1:0] cap);
        drain_responses();
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= cap;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // A pool of keys reused through a phase, so that hits, updates and
    // evictions are common. Some pools hold keys that differ from one base in
    // a single bit, which stresses the full-width key compare.
    task automatic build_key_pool(int n);
        logic [KEY_W-1:0] base;
        bit               near_base;
        base      = $urandom();
        near_base = ($urandom_range(0, 2) == 0);
        key_pool.delete();
        for (int i = 0; i < n; i++) begin
            if (near_base) begin
                key_pool.push_back(base ^ (32'h1 << $urandom_range(0, 31)));
            end else begin
                key_pool.push_back($urandom());
            end
        end
    endtask

    // The first phases walk the capacity extremes, including the values that
    // are clamped to one and to the full store.
    function automatic logic [CAP_W-1:0] corner_capacity(int phase);
        case (phase)
            0:       return CAP_W'(1);
            1:       return CAP_W'(ENTRIES);
            2:       return CAP_W'(0);
            3:       return CAP_W'(31);
            4:       return CAP_W'(2);
            default: return CAP_W'(ENTRIES - 1);
        endcase
    endfunction

    initial begin
        int               random_done;
        int               phase;
        int               phase_len;
        int               pick;
        logic [KIND_W-1:0] op_kind;
        logic [KEY_W-1:0] op_key;

        i_rst_n         = 1'b0;
        quiet_phase     = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.kind     = KIND_INSERT;
        req_ch.key      = '0;
        req_ch.value    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset capacity: key and data extremes, a hit
        // and a miss of every kind, an update that returns no data, and the
        // undecoded kind.
        send_request(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_SEARCH, 32'h0000_0000, 32'h1234_5678);
        send_request(KIND_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_SEARCH, 32'h1234_5678, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
        send_request(KIND_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
        for (int k = 1; k <= 4; k++) begin
            send_request(KIND_INSERT, 32'(k), 32'(k * 32'h0101_0101));
        end

        // Capacity dropped below the occupancy: each new key evicts only the
        // least recent line, so the occupancy stays where it was.
        set_capacity(CAP_W'(2));
        send_request(KIND_INSERT, 32'h0000_0005, 32'h5555_5555);
        send_request(KIND_SEARCH, 32'h0000_0001, 32'h0000_0000);
        send_request(KIND_INSERT, 32'h0000_0006, 32'h6666_6666);
        send_request(KIND_INSERT, 32'h0000_0001, 32'h1111_1111);

        // Capacity zero behaves as one; deletes then bring the count down.
        set_capacity(CAP_W'(0));
        send_request(KIND_INSERT, 32'h0000_0007, 32'h7777_7777);
        send_request(KIND_DELETE, 32'h0000_0001, 32'h0000_0000);
        send_request(KIND_DELETE, 32'h0000_0007, 32'h0000_0000);
        send_request(KIND_INSERT, 32'h8000_0000, 32'h8000_0001);

        // Capacity above the store size behaves as the full store.
        set_capacity(CAP_W'(31));
        send_request(KIND_SEARCH, 32'h8000_0000, 32'h0000_0000);

        // Random phases, each at its own capacity and with its own key pool.
        random_done = 0;
        phase       = 0;
        while (random_done < RANDOM_REQUESTS) begin
            if (phase < 6) begin
                set_capacity(corner_capacity(phase));
            end else begin
                set_capacity(CAP_W'($urandom_range(0, 31)));
            end
            build_key_pool($urandom_range(2, 40));
            quiet_phase <= ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(60, 200);
            for (int n = 0; n < phase_len && random_done < RANDOM_REQUESTS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    op_kind = KIND_INSERT;
                end else if (pick < 75) begin
                    op_kind = KIND_SEARCH;
                end else if (pick < 95) begin
                    op_kind = KIND_DELETE;
                end else begin
                    op_kind = KIND_UNUSED;
                end
                if ($urandom_range(0, 9) == 0) begin
                    op_key = $urandom();
                end else begin
                    op_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                end
                send_request(op_kind, op_key, $urandom());
                if (op_kind != KIND_UNUSED) begin
                    random_done++;
                end
                // Occasionally let the pipeline run dry mid-phase.
                if ($urandom_range(0, 99) == 0) begin
                    drain_responses();
                end
            end
            phase++;
        end

        // Wind down: every response in, then a margin past the sequencer walk.
        drain_responses();
        repeat (4 * ENTRIES) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_req_if.sv
hw/rtl/lkv_rsp_if.sv
hw/rtl/lkv_cfg_if.sv
hw/rtl/lkv_store.sv
hw/rtl/lkv_rank.sv
hw/rtl/lru_key_value_cache.sv
dv/lkv_result_checker.sv
dv/tb.sv
